// ===== hw/rtl/bsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared widths, types and constants of the bounding-sphere accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

  localparam int COORD_BITS = 24;

  // Squared distance of three axes stays below 2^(2*COORD_BITS+2).
  localparam int PROD_BITS = 2 * COORD_BITS;
  localparam int SUM_BITS  = 2 * COORD_BITS + 2;
  localparam int ROOT_BITS = SUM_BITS / 2;
  localparam int REM_BITS  = ROOT_BITS + 2;
  localparam int GROW_BITS = ROOT_BITS + 1;
  localparam int CNT_BITS  = $clog2(ROOT_BITS);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] radius_t;

  localparam radius_t RADIUS_MAX = '1;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bounding_sphere_accumulate_core.sv =====
// ----------------------------------------------------------------------------
// bounding_sphere_accumulate_core
// Folds a stream of part spheres into one enclosing sphere, one transaction
// at a time, with a shared multiplier and a bit-serial square root.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------
//  in      | in_valid / in_stall | restart, sphere_present, center_x/y/z,
//          |                     | radius_in
//  out     | out_valid/out_stall | merged_x/y/z, merged_radius, saturated
//
//  An absent sphere, or one that lands in an empty accumulator, goes from
//  idle straight to the finish step. A full merge steps through difference,
//  square and sum for each axis in turn (one multiplier, three axes), a
//  bit-serial square root (one root bit per cycle), the radius growth step
//  and the finish step that loads the result.
//  in_stall is high in reset and while a transaction is in work. A held
//  result does not block the next input; the block waits only to load a new
//  result. Reset clears the accumulated sphere and the saturation flag.
`default_nettype none

module bounding_sphere_accumulate_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             restart,
  input  wire logic             sphere_present,
  input  wire bsa_pkg::coord_t  center_x,
  input  wire bsa_pkg::coord_t  center_y,
  input  wire bsa_pkg::coord_t  center_z,
  input  wire bsa_pkg::radius_t radius_in,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output bsa_pkg::coord_t       merged_x,
  output bsa_pkg::coord_t       merged_y,
  output bsa_pkg::coord_t       merged_z,
  output bsa_pkg::radius_t      merged_radius,
  output logic                  saturated
);
  import bsa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_ACC,
    ST_SQRT,
    ST_GROW,
    ST_FINISH
  } state_t;

  state_t state;

  coord_t  acc_x, acc_y, acc_z;
  radius_t acc_radius;
  logic    sat_flag;

  // Base sphere (kept) and the other sphere (absorbed)
  coord_t  base_x, base_y, base_z, oth_x, oth_y, oth_z;
  radius_t base_r, oth_r;

  axis_t                   axis;
  logic [COORD_BITS-1:0]   diff;
  logic [PROD_BITS-1:0]    prod;
  logic [SUM_BITS-1:0]     rad;
  logic [REM_BITS-1:0]     rem;
  logic [ROOT_BITS-1:0]    root;
  logic [CNT_BITS-1:0]     sq_cnt;

  logic                    accept;
  logic                    out_free;
  radius_t                 eff_radius;
  coord_t                  ax_b, ax_c;
  logic signed [COORD_BITS:0] delta;
  logic [COORD_BITS-1:0]   delta_abs;
  logic [REM_BITS+1:0]     rem_sh;
  logic [REM_BITS+1:0]     trial;
  logic                    take_bit;
  logic [GROW_BITS-1:0]    grown;

  assign in_stall   = rst || (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign eff_radius = restart ? '0 : acc_radius;

  always_comb begin
    case (axis)
      AXIS_X: begin
        ax_b = base_x;
        ax_c = oth_x;
      end
      AXIS_Y: begin
        ax_b = base_y;
        ax_c = oth_y;
      end
      AXIS_Z: begin
        ax_b = base_z;
        ax_c = oth_z;
      end
      default: begin
        ax_b = base_x;
        ax_c = oth_x;
      end
    endcase
  end

  assign delta     = {ax_c[COORD_BITS-1], ax_c} - {ax_b[COORD_BITS-1], ax_b};
  assign delta_abs = delta[COORD_BITS] ? COORD_BITS'(-delta) : delta[COORD_BITS-1:0];

  // One root bit per step: bring down two radicand bits, try 4*root+1
  assign rem_sh   = {rem, rad[SUM_BITS-1 -: 2]};
  assign trial    = (REM_BITS+2)'({root, 2'b01});
  assign take_bit = (rem_sh >= trial);

  assign grown = GROW_BITS'(oth_r) + GROW_BITS'(root);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      acc_x      <= '0;
      acc_y      <= '0;
      acc_z      <= '0;
      acc_radius <= '0;
      sat_flag   <= 1'b0;
      axis       <= AXIS_X;
      sq_cnt     <= '0;
    end else begin
      // the finish step reloads the output register itself
      if (out_valid && !out_stall && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (restart) begin
              sat_flag <= 1'b0;
            end
            if (sphere_present && eff_radius != '0) begin
              // incoming sphere is the base on equal radii
              if (eff_radius <= radius_in) begin
                base_x <= center_x;
                base_y <= center_y;
                base_z <= center_z;
                base_r <= radius_in;
                oth_x  <= acc_x;
                oth_y  <= acc_y;
                oth_z  <= acc_z;
                oth_r  <= eff_radius;
              end else begin
                base_x <= acc_x;
                base_y <= acc_y;
                base_z <= acc_z;
                base_r <= eff_radius;
                oth_x  <= center_x;
                oth_y  <= center_y;
                oth_z  <= center_z;
                oth_r  <= radius_in;
              end
              axis  <= AXIS_X;
              rad   <= '0;
              state <= ST_DIFF;
            end else begin
              if (sphere_present) begin
                acc_x      <= center_x;
                acc_y      <= center_y;
                acc_z      <= center_z;
                acc_radius <= radius_in;
              end else if (restart) begin
                acc_x      <= '0;
                acc_y      <= '0;
                acc_z      <= '0;
                acc_radius <= '0;
              end
              state <= ST_FINISH;
            end
          end
        end
        ST_DIFF: begin
          diff  <= delta_abs;
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod  <= PROD_BITS'(diff) * PROD_BITS'(diff);
          state <= ST_ACC;
        end
        ST_ACC: begin
          rad <= rad + SUM_BITS'(prod);
          if (axis == AXIS_Z) begin
            rem    <= '0;
            root   <= '0;
            sq_cnt <= '0;
            state  <= ST_SQRT;
          end else begin
            axis  <= (axis == AXIS_X) ? AXIS_Y : AXIS_Z;
            state <= ST_DIFF;
          end
        end
        ST_SQRT: begin
          rad  <= {rad[SUM_BITS-3:0], 2'b00};
          root <= {root[ROOT_BITS-2:0], take_bit};
          if (take_bit) begin
            rem <= REM_BITS'(rem_sh - trial);
          end else begin
            rem <= REM_BITS'(rem_sh);
          end
          if (sq_cnt == CNT_BITS'(ROOT_BITS - 1)) begin
            state <= ST_GROW;
          end else begin
            sq_cnt <= sq_cnt + CNT_BITS'(1);
          end
        end
        ST_GROW: begin
          acc_x <= base_x;
          acc_y <= base_y;
          acc_z <= base_z;
          if (grown > GROW_BITS'(base_r)) begin
            if (grown > GROW_BITS'(RADIUS_MAX)) begin
              acc_radius <= RADIUS_MAX;
              sat_flag   <= 1'b1;
            end else begin
              acc_radius <= grown[COORD_BITS-1:0];
            end
          end else begin
            acc_radius <= base_r;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          // hold until the output register can take the result
          if (out_free) begin
            merged_x      <= acc_x;
            merged_y      <= acc_y;
            merged_z      <= acc_z;
            merged_radius <= acc_radius;
            saturated     <= sat_flag;
            out_valid     <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Saturation pins the radius at its maximum until a restart
  a_sat_radius: assert property (@(posedge clk) disable iff (rst)
    sat_flag |-> acc_radius == RADIUS_MAX)
    else $error("saturation flag set with radius below maximum");

  a_out_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> merged_radius == RADIUS_MAX)
    else $error("saturated result with radius below maximum");

  a_grow_mono: assert property (@(posedge clk) disable iff (rst)
    state == ST_GROW |=> acc_radius >= $past(base_r))
    else $error("merged radius shrank below base radius");

  a_sqrt_len: assert property (@(posedge clk) disable iff (rst)
    state == ST_SQRT |-> sq_cnt <= CNT_BITS'(ROOT_BITS - 1))
    else $error("square root step count overran");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives part spheres into bounding_sphere_accumulate_core and checks every
// merged sphere against a cycle-free fold of the same stream, under random
// gaps on both channels and one long output hold-off.
// ----------------------------------------------------------------------------

module tb_top;
  import bsa_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 2 * (COORD_BITS + 13);
  localparam int MAX_SHOWN    = 10;
  localparam int RANDOM_ITEMS = 600;

  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  typedef struct packed {
    coord_t  x;
    coord_t  y;
    coord_t  z;
    radius_t radius;
    logic    sat;
  } sphere_result_t;

  logic    clk            = 1'b0;
  logic    rst            = 1'b1;
  logic    in_valid       = 1'b0;
  logic    in_stall;
  logic    restart        = 1'b0;
  logic    sphere_present = 1'b0;
  coord_t  center_x       = '0;
  coord_t  center_y       = '0;
  coord_t  center_z       = '0;
  radius_t radius_in      = '0;
  logic    out_valid;
  logic    out_stall      = 1'b0;
  coord_t  merged_x;
  coord_t  merged_y;
  coord_t  merged_z;
  radius_t merged_radius;
  logic    saturated;

  bounding_sphere_accumulate_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .restart        (restart),
    .sphere_present (sphere_present),
    .center_x       (center_x),
    .center_y       (center_y),
    .center_z       (center_z),
    .radius_in      (radius_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .merged_x       (merged_x),
    .merged_y       (merged_y),
    .merged_z       (merged_z),
    .merged_radius  (merged_radius),
    .saturated      (saturated)
  );

  // Running enclosing sphere as the testbench sees it.
  coord_t  hull_x      = '0;
  coord_t  hull_y      = '0;
  coord_t  hull_z      = '0;
  radius_t hull_radius = '0;
  logic    hull_sat    = 1'b0;

  sphere_result_t expected_spheres[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_left     = 0;
  int mismatches    = 0;
  int cycle_count   = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** bounding_sphere_accumulate_core: FAILED **");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = COORD_BITS + 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Fold one part sphere into the running sphere and return what it reports.
  function automatic sphere_result_t fold_sphere(input logic rs, input logic pres,
                                                 input coord_t px, input coord_t py,
                                                 input coord_t pz, input radius_t pr);
    coord_t         bx, by, bz, sx, sy, sz;
    logic [63:0]    br, sr, dist2, grown;
    longint         dx, dy, dz;
    sphere_result_t res;
    if (rs) begin
      hull_x = '0;
      hull_y = '0;
      hull_z = '0;
      hull_radius = '0;
      hull_sat = 1'b0;
    end
    if (pres) begin
      if (hull_radius == '0) begin
        hull_x = px;
        hull_y = py;
        hull_z = pz;
        hull_radius = pr;
      end else begin
        // Incoming sphere wins the base on a tie.
        if (hull_radius <= pr) begin
          bx = px; by = py; bz = pz; br = 64'(pr);
          sx = hull_x; sy = hull_y; sz = hull_z; sr = 64'(hull_radius);
        end else begin
          bx = hull_x; by = hull_y; bz = hull_z; br = 64'(hull_radius);
          sx = px; sy = py; sz = pz; sr = 64'(pr);
        end
        dx = longint'(sx) - longint'(bx);
        dy = longint'(sy) - longint'(by);
        dz = longint'(sz) - longint'(bz);
        dist2 = dx * dx + dy * dy + dz * dz;
        grown = sr + int_sqrt(dist2);
        if (grown > br) begin
          if (grown > 64'(RADIUS_MAX)) begin
            br = 64'(RADIUS_MAX);
            hull_sat = 1'b1;
          end else begin
            br = grown;
          end
        end
        hull_x = bx;
        hull_y = by;
        hull_z = bz;
        hull_radius = br[COORD_BITS-1:0];
      end
    end
    res.x = hull_x;
    res.y = hull_y;
    res.z = hull_z;
    res.radius = hull_radius;
    res.sat = hull_sat;
    return res;
  endfunction

  task automatic send_part(input logic rs, input logic pres, input coord_t px,
                           input coord_t py, input coord_t pz, input radius_t pr);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    restart        <= rs;
    sphere_present <= pres;
    center_x       <= px;
    center_y       <= py;
    center_z       <= pz;
    radius_in      <= pr;
    in_valid       <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_spheres.push_back(fold_sphere(rs, pres, px, py, pz, pr));
  endtask

  task automatic check_result();
    sphere_result_t want;
    if (expected_spheres.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("unexpected result: x=%0d y=%0d z=%0d r=%0d sat=%0b",
                 merged_x, merged_y, merged_z, merged_radius, saturated);
    end else begin
      want = expected_spheres.pop_front();
      if (merged_x !== want.x || merged_y !== want.y || merged_z !== want.z ||
          merged_radius !== want.radius || saturated !== want.sat) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display({"mismatch: expected x=%0d y=%0d z=%0d r=%0d sat=%0b, ",
                    "got x=%0d y=%0d z=%0d r=%0d sat=%0b"},
                   want.x, want.y, want.z, want.radius, want.sat,
                   merged_x, merged_y, merged_z, merged_radius, saturated);
      end
    end
  endtask

  // Output side: check each transaction, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic coord_t rand_coord(input coord_t anchor);
    case ($urandom_range(9))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2, 3: return coord_t'($urandom);
      default: return anchor + coord_t'(int'($urandom_range(4095)) - 2048);
    endcase
  endfunction

  function automatic radius_t rand_radius(input radius_t near);
    case ($urandom_range(9))
      0: return '0;
      1: return RADIUS_MAX;
      2: return radius_t'($urandom);
      3: return radius_t'($urandom_range(255));
      4: return near;
      default: return radius_t'($urandom_range(65535));
    endcase
  endfunction

  task automatic test_empty_accumulator();
    send_part(1'b0, 1'b0, COORD_MAX, COORD_MIN, COORD_MAX, RADIUS_MAX);
    // zero radius leaves the accumulator empty but moves its center
    send_part(1'b0, 1'b1, coord_t'(100), coord_t'(-200), coord_t'(300), radius_t'(0));
    send_part(1'b0, 1'b1, coord_t'(5), coord_t'(6), coord_t'(7), radius_t'(256));
    send_part(1'b0, 1'b0, coord_t'(-1), coord_t'(-1), coord_t'(-1), radius_t'(1));
  endtask

  task automatic test_merge_rules();
    send_part(1'b0, 1'b1, coord_t'(5), coord_t'(6), coord_t'(7), radius_t'(256));
    send_part(1'b0, 1'b1, coord_t'(1000), coord_t'(6), coord_t'(7), radius_t'(256));
    send_part(1'b0, 1'b1, coord_t'(5), coord_t'(6), coord_t'(7), radius_t'(10));
    send_part(1'b0, 1'b1, coord_t'(-3000), coord_t'(0), coord_t'(0), 24'h100000);
    send_part(1'b0, 1'b1, coord_t'(-3000), coord_t'(0), coord_t'(0), radius_t'(0));
  endtask

  task automatic test_saturation();
    send_part(1'b1, 1'b1, COORD_MIN, COORD_MIN, COORD_MIN, radius_t'(1));
    send_part(1'b0, 1'b1, COORD_MAX, COORD_MAX, COORD_MAX, radius_t'(1));
    send_part(1'b0, 1'b1, coord_t'(0), coord_t'(0), coord_t'(0), RADIUS_MAX);
    send_part(1'b0, 1'b0, coord_t'(0), coord_t'(0), coord_t'(0), radius_t'(0));
    send_part(1'b1, 1'b0, coord_t'(0), coord_t'(0), coord_t'(0), radius_t'(0));
  endtask

  task automatic test_restart();
    send_part(1'b1, 1'b1, COORD_MAX, COORD_MIN, coord_t'(0), RADIUS_MAX);
    send_part(1'b0, 1'b1, COORD_MIN, COORD_MAX, COORD_MIN, radius_t'(0));
    send_part(1'b1, 1'b1, coord_t'(-1), coord_t'(-1), coord_t'(-1), 24'h800000);
    send_part(1'b0, 1'b1, coord_t'(1), coord_t'(1), coord_t'(1), 24'h7FFFFF);
    send_part(1'b1, 1'b1, coord_t'(0), coord_t'(0), coord_t'(0), radius_t'(0));
  endtask

  // Mostly restart-led runs of spheres around a shared anchor, with some noise.
  task automatic test_random(input int n_items);
    int     done;
    int     run_len;
    logic   rs;
    coord_t ax, ay, az;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(1) == 0) begin
        ax = coord_t'($urandom);
        ay = coord_t'($urandom);
        az = coord_t'($urandom);
      end else begin
        ax = coord_t'(int'($urandom_range(65535)) - 32768);
        ay = coord_t'(int'($urandom_range(65535)) - 32768);
        az = coord_t'(int'($urandom_range(65535)) - 32768);
      end
      run_len = $urandom_range(1, 12);
      for (int i = 0; i < run_len; i++) begin
        rs = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
        send_part(rs, $urandom_range(9) != 0, rand_coord(ax), rand_coord(ay),
                  rand_coord(az), rand_radius(hull_radius));
        done++;
      end
    end
  endtask

  // Hold the output off long enough that the block backs up into its input.
  task automatic test_full_stall();
    hold_req = 400;
    for (int i = 0; i < 24; i++)
      send_part($urandom_range(7) == 0, 1'b1, coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), radius_t'($urandom_range(65535)));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 37;
    recv_idle_pct = 69;
    test_empty_accumulator();
    test_merge_rules();
    test_saturation();
    test_restart();
    test_random(RANDOM_ITEMS);

    send_idle_pct = 69;
    recv_idle_pct = 37;
    test_random(RANDOM_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(RANDOM_ITEMS);
    test_full_stall();

    in_valid <= 1'b0;
    while (expected_spheres.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_spheres.size() == 0)
      $display("** bounding_sphere_accumulate_core: PASSED **");
    else
      $display("** bounding_sphere_accumulate_core: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bsa_pkg.sv
hw/rtl/bounding_sphere_accumulate_core.sv
tb/tb_top.sv
